>>> rtl/gyro_bias_highpass_filter_assert.svh
// Assertion macros shared by the gyro high-pass RTL.
`ifndef GYRO_BIAS_HIGHPASS_FILTER_ASSERT_SVH
`define GYRO_BIAS_HIGHPASS_FILTER_ASSERT_SVH
`ifndef SYNTH
`define GBHP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbhp: same-cycle check failed");
`define GBHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbhp: next-cycle check failed");
`define GBHP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("gbhp: forbidden condition seen");
`else
`define GBHP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define GBHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define GBHP_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> rtl/gbhp_pkg.sv
`default_nettype none
package gbhp_pkg;

    localparam int AXES       = 3;
    localparam int RAW_W      = 16;
    localparam int RATE_W     = 32;
    localparam int TIME_W     = 64;
    localparam int SCALE_W    = 32;
    localparam int COEFF_W    = 16;
    localparam int TERM_W     = COEFF_W + 1;   // 2*b and 1+b reach 2^16
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int S_TDATA_W = AXES * RAW_W + TIME_W;
    localparam int M_TDATA_W = AXES * RATE_W + TIME_W;

    // scale path: Q0 * Q8.24 -> Q.24, round to Q.20
    localparam int PROD_W   = RAW_W + SCALE_W + 1;
    localparam int X_SHIFT  = 4;
    localparam int ROUND_X  = 8;
    localparam int SCL_W    = PROD_W - X_SHIFT;
    localparam int CORR_W   = SCL_W + 1;

    // filter path: Q.36 accumulator, round to Q.20
    localparam int SAT_W    = 52;
    localparam int Y_SHIFT  = 16;
    localparam int ROUND_Y  = 32768;
    localparam int RND_W    = SAT_W - Y_SHIFT;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [SCALE_W-1:0] SCALE_RST = 32'd16777216;
    localparam logic [COEFF_W-1:0] COEFF_RST = 16'd32112;
    localparam logic [COEFF_W-1:0] COEFF_ONE = 16'd32768;

    localparam logic [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_Z     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HPF_COEFF  = 3'd4;

    typedef struct packed {
        logic [SCALE_W-1:0]           scale;
        logic [AXES-1:0][RATE_W-1:0]  bias;
        logic [TERM_W-1:0]            pole2;   // 2*b, b clamped to one
        logic [TERM_W-1:0]            gain;    // one + b
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]            ts;
        logic [AXES-1:0][RATE_W-1:0]  x;
        logic                         clip;
    } t_sample;

    typedef struct packed {
        logic               clip;
        logic [RATE_W-1:0]  val;
    } t_sat;

    function automatic t_sat sat32(input logic signed [SAT_W-1:0] v);
        t_sat r;
        logic hi;
        logic lo;
        hi = !v[SAT_W-1] && (|v[SAT_W-2:RATE_W-1]);
        lo = v[SAT_W-1] && !(&v[SAT_W-2:RATE_W-1]);
        r.clip = hi || lo;
        if (hi) begin
            r.val = RATE_MAX;
        end else if (lo) begin
            r.val = RATE_MIN;
        end else begin
            r.val = v[RATE_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/gbhp_regs.sv
`default_nettype none
module gbhp_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gbhp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gbhp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output gbhp_pkg::t_cfg                     o_cfg
);
    import gbhp_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    // pole terms are precomputed at write time, b above one reads as one
    function automatic logic [2*TERM_W-1:0] coeff_terms(input logic [COEFF_W-1:0] c);
        logic [COEFF_W-1:0] b;
        b = (c > COEFF_ONE) ? COEFF_ONE : c;
        return {{b, 1'b0}, TERM_W'(COEFF_ONE) + {1'b0, b}};
    endfunction

    assign o_cfg_ready = 1'b1;
    assign w_wr        = i_cfg_valid && o_cfg_ready;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale               <= SCALE_RST;
            r_cfg.bias                <= '0;
            {r_cfg.pole2, r_cfg.gain} <= coeff_terms(COEFF_RST);
        end else if (w_wr) begin
            unique case (i_cfg_index)
                REG_GYRO_SCALE: r_cfg.scale   <= i_cfg_data[SCALE_W-1:0];
                REG_BIAS_X:     r_cfg.bias[0] <= i_cfg_data[RATE_W-1:0];
                REG_BIAS_Y:     r_cfg.bias[1] <= i_cfg_data[RATE_W-1:0];
                REG_BIAS_Z:     r_cfg.bias[2] <= i_cfg_data[RATE_W-1:0];
                REG_HPF_COEFF:  {r_cfg.pole2, r_cfg.gain} <= coeff_terms(i_cfg_data[COEFF_W-1:0]);
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/gbhp_front.sv
`default_nettype none
module gbhp_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gbhp_pkg::t_cfg                    i_cfg,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [gbhp_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  logic                              i_q_full,
    output logic                              o_push,
    output gbhp_pkg::t_sample                 o_sample
);
    import gbhp_pkg::*;

    logic                      r_p_valid;
    logic signed [PROD_W-1:0]  r_prod [AXES];
    logic [TIME_W-1:0]         r_ts;

    logic signed [RAW_W-1:0]   w_raw  [AXES];
    logic signed [PROD_W-1:0]  w_prod [AXES];
    logic [PROD_W-1:0]         w_rnd  [AXES];
    logic signed [SCL_W-1:0]   w_scl  [AXES];
    logic signed [CORR_W-1:0]  w_corr [AXES];
    t_sat                      w_sat  [AXES];
    logic                      w_accept;

    assign o_s_tready = !r_p_valid || !i_q_full;
    assign o_push     = r_p_valid && !i_q_full;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        o_sample.ts   = r_ts;
        o_sample.clip = 1'b0;
        o_sample.x    = '0;
        for (int a = 0; a < AXES; a++) begin
            w_raw[a]  = i_s_tdata[a*RAW_W +: RAW_W];
            w_prod[a] = w_raw[a] * $signed({1'b0, i_cfg.scale});
            // round half up from 24 to 20 fraction bits
            w_rnd[a]  = r_prod[a] + PROD_W'(ROUND_X);
            w_scl[a]  = w_rnd[a][PROD_W-1:X_SHIFT];
            w_corr[a] = CORR_W'(w_scl[a]) - CORR_W'($signed(i_cfg.bias[a]));
            w_sat[a]  = sat32(SAT_W'(w_corr[a]));
            o_sample.x[a] = w_sat[a].val;
            o_sample.clip = o_sample.clip | w_sat[a].clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_p_valid <= 1'b1;
                r_ts      <= i_s_tdata[AXES*RAW_W +: TIME_W];
                for (int a = 0; a < AXES; a++) begin
                    r_prod[a] <= w_prod[a];
                end
            end else if (o_push) begin
                r_p_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/gbhp_queue.sv
`default_nettype none
`include "gyro_bias_highpass_filter_assert.svh"
module gbhp_queue #(
    parameter int DEPTH = gbhp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gbhp_pkg::t_sample  i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output gbhp_pkg::t_sample  o_data
);
    import gbhp_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // shift queue: head always sits in entry 0
    t_sample            r_q [DEPTH];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   w_widx;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_q[0];
    assign w_widx  = i_pop ? r_count - 1'b1 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (i_push && w_widx == CNT_W'(i)) begin
                r_q[i] <= i_data;
            end else if (i_pop && i < DEPTH - 1) begin
                r_q[i] <= r_q[(i + 1) % DEPTH];
            end
        end
    end

    `GBHP_ASSERT_NEVER(a_q_no_overflow, i_clk, i_rst_n, i_push && o_full && !i_pop)
    `GBHP_ASSERT_NEVER(a_q_no_underflow, i_clk, i_rst_n, i_pop && !o_valid)
    `GBHP_ASSERT_NEXT(a_q_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule
`default_nettype wire

>>> rtl/gbhp_back.sv
`default_nettype none
`include "gyro_bias_highpass_filter_assert.svh"
module gbhp_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gbhp_pkg::t_cfg                    i_cfg,
    input  logic                              i_q_valid,
    input  gbhp_pkg::t_sample                 i_q_data,
    output logic                              o_q_pop,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [gbhp_pkg::M_TDATA_W-1:0]    o_m_tdata,
    output logic                              o_m_tuser
);
    import gbhp_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_ACC
    } t_state;

    t_state                     r_state;
    logic signed [SAT_W-1:0]    r_pa [AXES];
    logic signed [SAT_W-1:0]    r_pb [AXES];
    logic [AXES-1:0][RATE_W-1:0] r_x;
    logic [TIME_W-1:0]          r_ts;
    logic                       r_clip;
    logic signed [RATE_W-1:0]   r_prev_x [AXES];
    logic signed [RATE_W-1:0]   r_prev_y [AXES];

    logic                       r_out_valid;
    logic [AXES-1:0][RATE_W-1:0] r_out_y;
    logic [TIME_W-1:0]          r_out_ts;
    logic                       r_out_clip;

    logic                       w_load;
    logic                       w_pop;
    logic signed [RATE_W:0]     w_diff [AXES];
    logic signed [SAT_W-1:0]    w_pa   [AXES];
    logic signed [SAT_W-1:0]    w_pb   [AXES];
    logic [SAT_W-1:0]           w_acc  [AXES];
    logic signed [RND_W-1:0]    w_rnd  [AXES];
    t_sat                       w_res  [AXES];
    logic                       w_clip;

    always_comb begin
        w_load = !r_out_valid || i_m_tready;
        w_pop  = (r_state == S_IDLE) && i_q_valid;
        w_clip = r_clip;
        for (int a = 0; a < AXES; a++) begin
            w_diff[a] = (RATE_W + 1)'($signed(i_q_data.x[a])) - (RATE_W + 1)'(r_prev_x[a]);
            w_pa[a]   = $signed({1'b0, i_cfg.pole2}) * r_prev_y[a];
            w_pb[a]   = $signed({1'b0, i_cfg.gain}) * w_diff[a];
            w_acc[a]  = r_pa[a] + r_pb[a] + SAT_W'(ROUND_Y);
            w_rnd[a]  = w_acc[a][SAT_W-1:Y_SHIFT];
            w_res[a]  = sat32(SAT_W'(w_rnd[a]));
            w_clip    = w_clip | w_res[a].clip;
        end
    end

    assign o_q_pop    = w_pop;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_ts, r_out_y};
    assign o_m_tuser  = r_out_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                r_prev_x[a] <= '0;
                r_prev_y[a] <= '0;
            end
        end else begin
            if (r_state == S_ACC && w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        r_x     <= i_q_data.x;
                        r_ts    <= i_q_data.ts;
                        r_clip  <= i_q_data.clip;
                        for (int a = 0; a < AXES; a++) begin
                            r_pa[a] <= w_pa[a];
                            r_pb[a] <= w_pb[a];
                        end
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (w_load) begin
                        for (int a = 0; a < AXES; a++) begin
                            r_prev_x[a] <= $signed(r_x[a]);
                            r_prev_y[a] <= $signed(w_res[a].val);
                            r_out_y[a]  <= w_res[a].val;
                        end
                        r_out_ts   <= r_ts;
                        r_out_clip <= w_clip;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `GBHP_ASSERT_NEXT(a_pop_enters_acc, i_clk, i_rst_n, w_pop, r_state == S_ACC)
    `GBHP_ASSERT_NEXT(a_acc_shows_word, i_clk, i_rst_n, r_state == S_ACC && w_load, r_out_valid && r_state == S_IDLE)

endmodule
`default_nettype wire

>>> rtl/gyro_bias_highpass_filter.sv
`default_nettype none
// Three-axis gyro bias removal and first-order high-pass filter. Each input word
// carries raw x/y/z counts and a timestamp; each output word carries the three
// Q12.20 filtered rates, the same timestamp, and a clip flag in tuser. The front
// end takes a word every cycle while its product register or the small queue
// behind it has room (scale multiply registered, then round, bias and saturate).
// The filter end finishes each word before it takes the next from the queue: for
// the per-axis multiply-add of the recursive update, the products are registered,
// then accumulated, rounded, saturated and written back to the axis history.
// Config writes are always ready; write only while no words are in flight.
module gyro_bias_highpass_filter #(
    parameter int QUEUE_DEPTH = gbhp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // raw_x[15:0], raw_y[31:16], raw_z[47:32], sample_time[111:48]
    input  logic [gbhp_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // filtered_x[31:0], filtered_y[63:32], filtered_z[95:64], out_time[159:96]
    output logic [gbhp_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // clipped[0]
    output logic                              m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gbhp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gbhp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gbhp_pkg::*;

    t_cfg    w_cfg;
    t_sample w_push_data;
    t_sample w_head;
    logic    w_push;
    logic    w_full;
    logic    w_pop;
    logic    w_head_valid;

    gbhp_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    gbhp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_sample   (w_push_data)
    );

    gbhp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_data  (w_head)
    );

    gbhp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_q_valid  (w_head_valid),
        .i_q_data   (w_head),
        .o_q_pop    (w_pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire
